[sv/rme_pkg.sv]
// Shared types and constants for the running median engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  localparam int HeapDepthDef = 512;
  localparam int SampleW      = 32;
  localparam int MedianW      = 33;
  localparam int CountW       = 11;

  // Operation applied to every cell of a sorted chain in parallel.
  typedef enum logic [1:0] {
    OpHold,
    OpPush,     // insert x in rank order
    OpReplace   // drop the head, insert x in rank order
  } rme_op_e;

  typedef struct packed {
    rme_op_e                   op;
    logic signed [SampleW-1:0] x;
  } rme_cmd_t;

endpackage
`default_nettype wire

[sv/running_median_engine.sv]
// Running median engine, top level. Two rank-ordered cell chains hold the
// lower and upper halves of the stream. Depends on rme_pkg and rme_chain.
//
// One sample is taken when start_i is high and busy_o is low. At that edge
// each chain it reaches updates all cells in parallel (insert, or drop-head
// plus insert to rebalance; dropped when full), and busy_o is high for
// the one cycle in which the result is registered from the chain heads, and
// done_o marks the result during the following cycle, in which the next
// sample may already be taken. There is no output back-pressure: a result is
// presented for exactly one cycle. The chain update is the critical path:
// the routing compare against the lower head, the command broadcast, then
// one 32-bit compare per cell plus a three-way select. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module running_median_engine #(
  parameter int HEAP_DEPTH = rme_pkg::HeapDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [rme_pkg::SampleW-1:0] sample_i,
  output logic                               done_o,
  output logic signed [rme_pkg::MedianW-1:0] median_twice_o,
  output logic [rme_pkg::CountW-1:0]         sample_count_o,
  output logic                               dropped_o
);
  import rme_pkg::*;

  localparam int SizeW  = $clog2(HEAP_DEPTH + 1);
  localparam int TotalW = SizeW + 1;

  logic [SizeW-1:0]          lo_size_q, lo_size_d, up_size_q, up_size_d;
  logic                      pend_q, drop_pend_q, drop_pend_d;
  logic                      done_q, drop_q;
  logic signed [MedianW-1:0] med_q, med_d;
  logic [CountW-1:0]         cnt_q;
  logic [TotalW-1:0]         total;
  logic signed [SampleW-1:0] lo_top, up_top;
  rme_cmd_t                  lo_cmd, up_cmd;
  logic                      accept, full, to_lower;

  assign accept   = start_i && !busy_o;
  assign total    = TotalW'(lo_size_q) + TotalW'(up_size_q);
  assign full     = (total == TotalW'(2 * HEAP_DEPTH));
  assign to_lower = (lo_size_q == '0) || (lo_top > sample_i);

  always_comb begin
    lo_cmd      = '{op: OpHold, x: sample_i};
    up_cmd      = '{op: OpHold, x: sample_i};
    lo_size_d   = lo_size_q;
    up_size_d   = up_size_q;
    drop_pend_d = drop_pend_q;
    if (accept) begin
      drop_pend_d = 1'b0;
      priority if (full) begin
        drop_pend_d = 1'b1;
      end else if (to_lower && (lo_size_q == up_size_q + SizeW'(1))) begin
        // lower is long: its top moves up, sample takes its place
        lo_cmd    = '{op: OpReplace, x: sample_i};
        up_cmd    = '{op: OpPush, x: lo_top};
        up_size_d = up_size_q + SizeW'(1);
      end else if (to_lower) begin
        lo_cmd    = '{op: OpPush, x: sample_i};
        lo_size_d = lo_size_q + SizeW'(1);
      end else if (up_size_q == lo_size_q + SizeW'(1)) begin
        up_cmd    = '{op: OpReplace, x: sample_i};
        lo_cmd    = '{op: OpPush, x: up_top};
        lo_size_d = lo_size_q + SizeW'(1);
      end else begin
        up_cmd    = '{op: OpPush, x: sample_i};
        up_size_d = up_size_q + SizeW'(1);
      end
    end
  end

  rme_chain #(
    .HeapDepth (HEAP_DEPTH),
    .SizeW     (SizeW)
  ) u_lower (
    .clk_i    (clk_i),
    .cmd_i    (lo_cmd),
    .is_max_i (1'b1),
    .size_i   (lo_size_q),
    .top_o    (lo_top)
  );

  rme_chain #(
    .HeapDepth (HEAP_DEPTH),
    .SizeW     (SizeW)
  ) u_upper (
    .clk_i    (clk_i),
    .cmd_i    (up_cmd),
    .is_max_i (1'b0),
    .size_i   (up_size_q),
    .top_o    (up_top)
  );

  // median from the updated chain heads
  always_comb begin
    med_d = '0;
    if (lo_size_q == up_size_q) begin
      if (lo_size_q != '0) begin
        med_d = MedianW'(lo_top) + MedianW'(up_top);
      end
    end else if (lo_size_q > up_size_q) begin
      med_d = MedianW'(lo_top) <<< 1;
    end else begin
      med_d = MedianW'(up_top) <<< 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_size_q   <= '0;
      up_size_q   <= '0;
      pend_q      <= 1'b0;
      drop_pend_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      lo_size_q   <= lo_size_d;
      up_size_q   <= up_size_d;
      pend_q      <= accept;
      drop_pend_q <= drop_pend_d;
      done_q      <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      med_q  <= med_d;
      cnt_q  <= CountW'(total);
      drop_q <= drop_pend_q;
    end
  end

  assign busy_o         = pend_q;
  assign done_o         = done_q;
  assign median_twice_o = med_q;
  assign sample_count_o = cnt_q;
  assign dropped_o      = drop_q;

endmodule
`default_nettype wire

[sv/rme_cell.sv]
// One storage cell of a sorted chain: holds one sample and updates from
// its neighbors and the broadcast command. Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rme_cell (
  input  logic                               clk_i,
  input  rme_pkg::rme_cmd_t                  cmd_i,
  input  logic                               is_max_i,
  input  logic                               first_i,
  input  logic                               occ_i,
  input  logic                               prev_g_i,
  input  logic signed [rme_pkg::SampleW-1:0] prev_val_i,
  input  logic                               next_g_i,
  input  logic signed [rme_pkg::SampleW-1:0] next_val_i,
  output logic                               g_o,
  output logic signed [rme_pkg::SampleW-1:0] val_o
);
  import rme_pkg::*;

  logic signed [SampleW-1:0] val_q, val_d;

  // g: this cell is occupied and ranks strictly above the incoming value
  assign g_o   = occ_i && (is_max_i ? (val_q > cmd_i.x) : (val_q < cmd_i.x));
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      OpHold:    val_d = val_q;
      OpPush:    val_d = g_o ? val_q : (prev_g_i ? cmd_i.x : prev_val_i);
      OpReplace: val_d = next_g_i ? next_val_i : ((first_i || g_o) ? cmd_i.x : val_q);
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

[sv/rme_chain.sv]
// Row of rme_cell instances kept in rank order, head cell is the top.
// Depends on rme_pkg and rme_cell.
`timescale 1ns / 1ps
`default_nettype none
module rme_chain #(
  parameter int HeapDepth = rme_pkg::HeapDepthDef,
  parameter int SizeW     = $clog2(HeapDepth + 1)
) (
  input  logic                               clk_i,
  input  rme_pkg::rme_cmd_t                  cmd_i,
  input  logic                               is_max_i,
  input  logic [SizeW-1:0]                   size_i,
  output logic signed [rme_pkg::SampleW-1:0] top_o
);
  import rme_pkg::*;

  logic signed [SampleW-1:0] val [HeapDepth];
  logic [HeapDepth-1:0]      g;

  for (genvar i = 0; i < HeapDepth; i++) begin : g_cell
    logic                      prev_g;
    logic signed [SampleW-1:0] prev_val;
    logic                      next_g;
    logic signed [SampleW-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_g   = 1'b1;
      assign prev_val = val[i];
    end else begin : g_body
      assign prev_g   = g[i-1];
      assign prev_val = val[i-1];
    end

    if (i == HeapDepth - 1) begin : g_tail
      assign next_g   = 1'b0;
      assign next_val = val[i];
    end else begin : g_inner
      assign next_g   = g[i+1];
      assign next_val = val[i+1];
    end

    rme_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .is_max_i   (is_max_i),
      .first_i    (i == 0),
      .occ_i      (SizeW'(i) < size_i),
      .prev_g_i   (prev_g),
      .prev_val_i (prev_val),
      .next_g_i   (next_g),
      .next_val_i (next_val),
      .g_o        (g[i]),
      .val_o      (val[i])
    );
  end

  assign top_o = val[0];

endmodule
`default_nettype wire

[sv/rme_checker.sv]
// Port-level timing checks for running_median_engine, bound to the top.
// Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rme_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [rme_pkg::CountW-1:0] sample_count_o
);
  import rme_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // a taken request shows busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy_o not raised after request");

  // every request yields its result strobe, registered from busy
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o) else $error("result strobe missing");

  // no result strobe without a matching earlier request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2)) else $error("result strobe without request");

  // a result always reports at least one stored sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sample_count_o != '0)) else $error("empty count in result");

endmodule

bind running_median_engine rme_checker u_rme_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .sample_count_o (sample_count_o)
);
`default_nettype wire
